// File: rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants for the bitmap slot allocator
// Word layout, action and status codes, controller states, leading-ones count.
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam int WORD_BITS = 64;
	localparam int SLOT_W    = 12;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_W     = 7;
	localparam int BIT_W     = 6;

	typedef logic [WORD_BITS-1:0] bsa_word_t;

	localparam bsa_word_t ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam bsa_word_t TOP_BIT  = 64'h8000_0000_0000_0000;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_REWIND = 2'd2,
		ACT_CLEAR  = 2'd3
	} bsa_action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} bsa_status_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_SCAN,
		S_FREE,
		S_DONE
	} bsa_state_t;

	// count of leading ones from the MSB; the highest zero bit wins
	function automatic logic [BIT_W-1:0] lead_ones(input bsa_word_t w);
		logic [BIT_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!w[i]) begin
				n = BIT_W'(WORD_BITS - 1 - i);
			end
		end
		return n;
	endfunction

endpackage

// File: rtl/bsa_if.sv
// ----------------------------------------------------------------------------
// bsa_if: valid/ready channels of the bitmap slot allocator
// Request, response and configuration write channels.
// ----------------------------------------------------------------------------
interface bsa_req_if;
	logic                        valid;
	logic                        ready;
	logic [bsa_pkg::ACT_W-1:0]   action;
	logic [bsa_pkg::SLOT_W-1:0]  free_index;

	modport source (output valid, output action, output free_index, input ready);
	modport sink   (input valid, input action, input free_index, output ready);
endinterface

interface bsa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bsa_pkg::SLOT_W-1:0]  slot_index;
	logic [bsa_pkg::STAT_W-1:0]  status;

	modport source (output valid, output slot_index, output status, input ready);
	modport sink   (input valid, input slot_index, input status, output ready);
endinterface

interface bsa_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [bsa_pkg::CFG_W-1:0]   words_in_use;

	modport source (output valid, output words_in_use, input ready);
	modport sink   (input valid, input words_in_use, output ready);
endinterface

// File: rtl/bsa_map_ram.sv
// ----------------------------------------------------------------------------
// bsa_map_ram: occupancy bitmap storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsa_map_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  bsa_pkg::bsa_word_t wdata,
	input  logic [AW-1:0]      raddr,
	output bsa_pkg::bsa_word_t rdata
);
	import bsa_pkg::*;

	bsa_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/bitmap_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_core: next-fit slot allocator over a bitmap memory
// Allocate, free, rewind and clear over MAX_WORDS words of 64 slots each.
// ----------------------------------------------------------------------------
//  channel  dir  transaction
//  cfg      in   words_in_use write, always ready
//  req      in   action, free_index
//  rsp      out  slot_index, status (one per request)
//
//  Allocate: reads the word at the hint, then one memory read per cycle while
//  each word read is full; done at once when the hint is already at the word count.
//  Free: read, modify, write. Rewind: no memory access.
//  Clear: a pass over all MAX_WORDS words, one word written per cycle.
//  After reset a clearing pass over all MAX_WORDS words runs with req.ready low.
//  A finished result waits in the output register; the next request is taken
//  meanwhile, and the block stalls only if that one finishes first.
module bitmap_slot_allocator_core #(
	parameter int MAX_WORDS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	bsa_cfg_if.sink  cfg,
	bsa_req_if.sink  req,
	bsa_rsp_if.source rsp
);
	import bsa_pkg::*;

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int HW = $clog2(MAX_WORDS + 1);

	bsa_state_t          state_q, state_d;
	logic [CFG_W-1:0]    words_q;
	logic [HW-1:0]       hint_q, hint_d;
	logic                hint_ld;
	logic [AW-1:0]       addr_q, addr_d;
	logic                addr_ld;
	logic [AW-1:0]       sweep_q;
	logic                init_q;
	logic [BIT_W-1:0]    fbit_q;
	logic [SLOT_W-1:0]   pend_slot_q, pend_slot_d;
	bsa_status_t         pend_stat_q, pend_stat_d;
	logic                pend_ld;
	logic                out_valid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	bsa_status_t         out_stat_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	bsa_word_t           ram_wdata, rdata;

	logic [HW-1:0]       count_w;
	logic                in_acc, out_free, found, scan_end, sweep_last, hint_ge, free_oor;
	logic [HW-1:0]       scan_next;
	logic [31:0]         fw32, aw32;
	logic [BIT_W-1:0]    lo;
	bsa_action_t         act;

	bsa_map_ram #(.DEPTH(MAX_WORDS), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign cfg.ready      = 1'b1;
	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.slot_index = out_slot_q;
	assign rsp.status     = out_stat_q;

	assign in_acc     = req.valid && req.ready;
	assign out_free   = !out_valid_q || rsp.ready;
	assign act        = bsa_action_t'(req.action);
	assign count_w    = (int'(words_q) > MAX_WORDS) ? HW'(MAX_WORDS) : HW'(words_q);
	assign fw32       = 32'(req.free_index[SLOT_W-1:BIT_W]);
	assign free_oor   = fw32 >= 32'(count_w);
	assign aw32       = 32'(addr_q);
	assign scan_next  = HW'(addr_q) + HW'(1);
	assign found      = rdata != ALL_ONES;
	assign scan_end   = scan_next >= count_w;
	assign lo         = lead_ones(rdata);
	assign sweep_last = sweep_q == AW'(MAX_WORDS - 1);
	assign hint_ge    = hint_q >= count_w;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_SWEEP: begin
				if (sweep_last) state_d = init_q ? S_IDLE : S_DONE;
			end
			S_IDLE: begin
				if (in_acc) begin
					case (act)
						ACT_ALLOC:  state_d = hint_ge ? S_DONE : S_SCAN;
						ACT_FREE:   state_d = free_oor ? S_DONE : S_FREE;
						ACT_REWIND: state_d = S_DONE;
						ACT_CLEAR:  state_d = S_SWEEP;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (found || scan_end) state_d = S_DONE;
			end
			S_FREE:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = addr_q;
		ram_wdata   = rdata;
		ram_raddr   = addr_q;
		addr_ld     = 1'b0;
		addr_d      = addr_q;
		hint_ld     = 1'b0;
		hint_d      = hint_q;
		pend_ld     = 1'b0;
		pend_slot_d = '0;
		pend_stat_d = STAT_DONE;
		case (state_q)
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				// word 0 gets slot zero marked taken: always after reset, after clear if words exist
				ram_wdata = (sweep_q == '0 && (init_q || count_w != '0)) ? TOP_BIT : '0;
				if (sweep_last && !init_q) begin
					pend_ld     = 1'b1;
					pend_stat_d = (count_w != '0) ? STAT_DONE : STAT_FULL;
					hint_ld     = 1'b1;
					hint_d      = '0;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					case (act)
						ACT_ALLOC: begin
							if (hint_ge) begin
								pend_ld     = 1'b1;
								pend_stat_d = STAT_FULL;
								hint_ld     = 1'b1;
								hint_d      = count_w;
							end else begin
								ram_raddr = hint_q[AW-1:0];
								addr_ld   = 1'b1;
								addr_d    = hint_q[AW-1:0];
							end
						end
						ACT_FREE: begin
							if (free_oor) begin
								pend_ld     = 1'b1;
								pend_stat_d = STAT_RANGE;
							end else begin
								ram_raddr = fw32[AW-1:0];
								addr_ld   = 1'b1;
								addr_d    = fw32[AW-1:0];
							end
						end
						ACT_REWIND: begin
							pend_ld = 1'b1;
							hint_ld = 1'b1;
							hint_d  = '0;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (found) begin
					ram_we      = 1'b1;
					ram_wdata   = rdata | (TOP_BIT >> lo);
					hint_ld     = 1'b1;
					hint_d      = HW'(addr_q);
					pend_ld     = 1'b1;
					pend_slot_d = {aw32[SLOT_W-BIT_W-1:0], lo};
				end else if (scan_end) begin
					pend_ld     = 1'b1;
					pend_stat_d = STAT_FULL;
					hint_ld     = 1'b1;
					hint_d      = count_w;
				end else begin
					// word full: fetch the next one, inspected next cycle
					ram_raddr = scan_next[AW-1:0];
					addr_ld   = 1'b1;
					addr_d    = scan_next[AW-1:0];
				end
			end
			S_FREE: begin
				ram_we    = 1'b1;
				ram_wdata = rdata & ~(TOP_BIT >> fbit_q);
				pend_ld   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			words_q     <= CFG_W'(64);
			hint_q      <= '0;
			sweep_q     <= '0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) words_q <= cfg.words_in_use;
			if (hint_ld) hint_q <= hint_d;
			if (state_q == S_SWEEP) begin
				sweep_q <= sweep_q + AW'(1);
				if (sweep_last) begin
					sweep_q <= '0;
					init_q  <= 1'b0;
				end
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (addr_ld) addr_q <= addr_d;
		if (in_acc) fbit_q <= req.free_index[BIT_W-1:0];
		if (pend_ld) begin
			pend_slot_q <= pend_slot_d;
			pend_stat_q <= pend_stat_d;
		end
		if (state_q == S_DONE && out_free) begin
			out_slot_q <= pend_slot_q;
			out_stat_q <= pend_stat_q;
		end
	end

endmodule

// File: rtl/bsa_checker.sv
// ----------------------------------------------------------------------------
// bsa_checker: port-level checks on the bitmap slot allocator
// Response coding, output stall behaviour and the post-reset clearing pass.
// ----------------------------------------------------------------------------
module bsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [11:0] rsp_slot_index,
	input logic [1:0]  rsp_status
);
	import bsa_pkg::*;

	// no request taken in the first cycle after reset: map still being cleared
	a_init_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !req_ready)
		else $error("request ready during post-reset clearing pass");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STAT_DONE || rsp_status == STAT_FULL
			|| rsp_status == STAT_RANGE))
		else $error("undefined status code");

	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_DONE |-> rsp_slot_index == '0)
		else $error("slot granted with failing status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_index)
			&& $stable(rsp_status))
		else $error("stalled response changed");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_slot_index (rsp.slot_index),
	.rsp_status     (rsp.status)
);
